[hdl/ccw_pkg.sv]
`default_nettype none

package ccw_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;

	// Field widths.
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int ADDR_W = 11;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int DATA_W = CHAR_W + ATTR_W;

	// Character codes with special handling.
	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CODE_BLANK     = 8'd32;

	// Attribute after reset.
	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h01;

	// Last row and last column as cursor values.
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

	// One result item.
	typedef struct packed {
		logic              write_valid;
		logic [ADDR_W-1:0] write_address;
		logic [DATA_W-1:0] write_data;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_col;
	} ccw_result_t;

endpackage

`default_nettype wire

[hdl/ccw_cursor.sv]
`default_nettype none

module ccw_cursor
	import ccw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic [CHAR_W-1:0] char_code,
	input  wire logic [ATTR_W-1:0] attribute,
	output ccw_result_t            result
);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_next;
	logic [COL_W-1:0] col_next;
	logic [ROW_W-1:0] row_down;
	logic [COL_W-1:0] addr_col;
	logic [CHAR_W-1:0] cell_char;
	logic             wr;

	// Row below the cursor, held on the last row since there is no scrolling.
	assign row_down = (row_q == ROW_LAST) ? row_q : row_q + ROW_W'(1);

	// Cursor update and cell write selection for one character.
	always_comb begin
		row_next  = row_q;
		col_next  = col_q;
		addr_col  = col_q;
		cell_char = char_code;
		wr        = 1'b0;
		case (char_code)
			CODE_NEWLINE: begin
				col_next = '0;
				row_next = row_down;
			end
			CODE_BACKSPACE: begin
				if (col_q != '0) begin
					col_next  = col_q - COL_W'(1);
					addr_col  = col_q - COL_W'(1);
					cell_char = CODE_BLANK;
					wr        = 1'b1;
				end
			end
			default: begin
				wr = 1'b1;
				if (col_q == COL_LAST) begin
					col_next = '0;
					row_next = row_down;
				end else begin
					col_next = col_q + COL_W'(1);
				end
			end
		endcase
	end

	// Result fields; address and data read zero when nothing is written.
	always_comb begin
		result.write_valid   = wr;
		result.write_address = '0;
		result.write_data    = '0;
		if (wr) begin
			result.write_address = ADDR_W'(row_q) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col);
			result.write_data    = {attribute, cell_char};
		end
		result.cursor_row = row_next;
		result.cursor_col = col_next;
	end

	// Cursor state moves once per item handed to the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (advance) begin
			row_q <= row_next;
			col_q <= col_next;
		end
	end

endmodule

`default_nettype wire

[hdl/text_console_cursor_writer.sv]
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   char_code
// result    out        out_valid/out_stall write_valid, write_address, write_data,
//                                          cursor_row, cursor_col
// config    in         cfg_wr_en           cfg_wr_data (colour attribute)
//
// One item per cycle is sustained while the result is not stalled.
// The path is an input register, the cursor logic, and a result register.
// Reset puts the cursor at row 0, column 0 and the attribute at 1.
// A stalled result holds its register; the input register keeps accepting
// as long as the result register can take its item.

module text_console_cursor_writer
	import ccw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CHAR_W-1:0] char_code,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   write_valid,
	output logic [ADDR_W-1:0]      write_address,
	output logic [DATA_W-1:0]      write_data,
	output logic [ROW_W-1:0]       cursor_row,
	output logic [COL_W-1:0]       cursor_col,
	input  wire logic              cfg_wr_en,
	input  wire logic [ATTR_W-1:0] cfg_wr_data
);

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              valid_s2;
	ccw_result_t       result_s2;
	ccw_result_t       result;
	logic [ATTR_W-1:0] attr_q;
	logic              advance;

	// The result register takes a new item when empty or being drained.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_code;
		end
	end

	// Cursor state and per-character logic.
	ccw_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.char_code (char_s1),
		.attribute (attr_q),
		.result    (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign write_valid   = result_s2.write_valid;
	assign write_address = result_s2.write_address;
	assign write_data    = result_s2.write_data;
	assign cursor_row    = result_s2.cursor_row;
	assign cursor_col    = result_s2.cursor_col;

endmodule

`default_nettype wire
